// ===== sv/bdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, command and status codes and ring index helpers for the deque core.
// ----------------------------------------------------------------------------
package bdeq_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int DATA_W = 32;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_DUMP       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   function automatic idx_type idx_inc(input idx_type idx);
      return (idx == idx_type'(DEPTH - 1)) ? '0 : idx + idx_type'(1);
   endfunction

   function automatic idx_type idx_dec(input idx_type idx);
      return (idx == '0) ? idx_type'(DEPTH - 1) : idx - idx_type'(1);
   endfunction

   // slot behind the back element; front + count stays below twice the depth
   function automatic idx_type back_slot(input idx_type front, input cnt_type count);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(front) + SUM_W'(count);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== sv/bdeq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque channels
// Command channel into the deque and result channel out of it.
// ----------------------------------------------------------------------------
interface bdeq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
   modport monitor (input valid, input ready, input command, input value);
endinterface

interface bdeq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] element;
   logic               last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink   (input valid, input status, input element, input last, output ready);
   modport monitor (input valid, input ready, input status, input element, input last);
endinterface

// ===== sv/bounded_deque_with_dump_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with dump
// Double-ended queue of signed words held in a ring buffer memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per beat (push front/back, pop front/back,
//   dump) with its data word. rsp_chan returns status, element and last.
//   A push or pop gives one result beat, registered, in the cycle after the
//   command is taken; one command a cycle is taken while the result stage
//   drains. A push onto a full queue reports full, a pop or dump of an empty
//   queue reports empty. A dump of N elements gives N beats, front to back,
//   one a cycle while rsp_chan does not stall, the last one marked; each word
//   is read through the registered ring memory port before it is moved into
//   the result register. No new command is taken until the final dump beat is
//   in the result register.
//   Unused command codes are taken and give no result.
//   Reset empties the queue and drops any pending result; memory contents
//   are not cleared. When rsp_chan stalls, the result register holds and
//   req_chan.ready falls until the beat is taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_dump_core
   import bdeq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   bdeq_req_if.sink     req_chan,
   bdeq_rsp_if.source   rsp_chan
);

   logic signed [DATA_W-1:0] mem [DEPTH];

   state_type                state_ff, state_in;
   idx_type                  front_ff, front_in;
   cnt_type                  count_ff, count_in;
   idx_type                  rd_idx_ff, rd_idx_in;
   cnt_type                  remain_ff, remain_in;
   logic signed [DATA_W-1:0] rd_data_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] element_ff, element_in;
   logic                     last_ff, last_in;

   logic                     wr_en;
   idx_type                  wr_addr;
   logic                     out_free;
   logic                     accept;
   logic                     full;
   logic                     empty;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == cnt_type'(DEPTH));
   assign empty          = (count_ff == '0);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = status_ff;
   assign rsp_chan.element = element_ff;
   assign rsp_chan.last    = last_ff;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               element_in = '0;
               last_in    = 1'b1;
               status_in  = STS_OK;
               unique case (req_chan.command)
                  CMD_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        status_in = STS_FULL;
                     end else begin
                        front_in = idx_dec(front_ff);
                        wr_en    = 1'b1;
                        wr_addr  = idx_dec(front_ff);
                        count_in = count_ff + cnt_type'(1);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        status_in = STS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_slot(front_ff, count_ff);
                        count_in = count_ff + cnt_type'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        front_in = idx_inc(front_ff);
                        count_in = count_ff - cnt_type'(1);
                     end
                  end
                  CMD_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        count_in = count_ff - cnt_type'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STS_EMPTY;
                     end else begin
                        // front word is read this cycle, ready next cycle
                        state_in  = ST_DUMP;
                        rd_idx_in = front_ff;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                     // unused code: drop the beat
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STS_OK;
               element_in   = rd_data_ff;
               last_in      = (remain_ff == cnt_type'(1));
               rd_idx_in    = idx_inc(rd_idx_ff);
               remain_in    = remain_ff - cnt_type'(1);
               if (remain_ff == cnt_type'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_chan.value;
      end
      rd_data_ff <= mem[rd_idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
   end

endmodule

// ===== sv/bdeq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque checker
// Port-level checks on the deque core, attached by bind.
// ----------------------------------------------------------------------------
module bdeq_checker
   import bdeq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_element,
   input  logic               rsp_last
);

   // a stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // push and pop commands answer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_command == CMD_PUSH_FRONT || req_command == CMD_PUSH_BACK ||
       req_command == CMD_POP_FRONT  || req_command == CMD_POP_BACK)
      |=> rsp_valid)
      else $error("push or pop gave no result beat");

   // error status carries no element and closes the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK)
      |-> (rsp_element == '0) && rsp_last)
      else $error("error status with element or without last");

   // hold off commands while a dump is still emitting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command taken during dump");

endmodule

bind bounded_deque_with_dump_core bdeq_checker u_bdeq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_command (req_chan.command),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_element (rsp_chan.element),
   .rsp_last    (rsp_chan.last)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with dump - testbench
// Drives push, pop, dump and unused commands into the deque core and checks
// every result beat against a ring buffer predictor held in the bench. Covers
// empty and full queues, wrap of the ring, long dumps under back-pressure and
// random traffic with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb
   import bdeq_pkg::*;
();

   typedef struct {
      status_type         status;
      logic signed [31:0] element;
      logic               last;
   } rsp_beat_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic clock;
   logic reset;

   bdeq_req_if req_bus ();
   bdeq_rsp_if rsp_bus ();

   bounded_deque_with_dump_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // bench copy of the deque
   logic signed [31:0] ring_words [DEPTH];
   int                 ring_front;
   int                 ring_count;
   rsp_beat_type       expected_beats [$];

   int          idle_pct;
   int          stall_pct;
   int          fail_count;
   int unsigned quiet_cycles;

   always #10 clock = ~clock;

   // work out the beats one accepted command should produce
   function automatic void deque_apply(input logic [2:0] cmd, input logic signed [31:0] val);
      rsp_beat_type beat;
      int           i;
      beat.status  = STS_OK;
      beat.element = '0;
      beat.last    = 1'b1;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (ring_count == DEPTH) begin
               beat.status = STS_FULL;
            end else begin
               ring_front = (ring_front + DEPTH - 1) % DEPTH;
               ring_words[ring_front] = val;
               ring_count++;
            end
         end
         CMD_PUSH_BACK: begin
            if (ring_count == DEPTH) begin
               beat.status = STS_FULL;
            end else begin
               ring_words[(ring_front + ring_count) % DEPTH] = val;
               ring_count++;
            end
         end
         CMD_POP_FRONT: begin
            if (ring_count == 0) begin
               beat.status = STS_EMPTY;
            end else begin
               ring_front = (ring_front + 1) % DEPTH;
               ring_count--;
            end
         end
         CMD_POP_BACK: begin
            if (ring_count == 0) begin
               beat.status = STS_EMPTY;
            end else begin
               ring_count--;
            end
         end
         CMD_DUMP: begin
            if (ring_count == 0) begin
               beat.status = STS_EMPTY;
            end else begin
               for (i = 0; i < ring_count; i++) begin
                  beat.element = ring_words[(ring_front + i) % DEPTH];
                  beat.last    = (i == ring_count - 1);
                  expected_beats.push_back(beat);
               end
               return;
            end
         end
         default: return;  // unused codes: no result, no state change
      endcase
      expected_beats.push_back(beat);
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_cmd(input logic [2:0] cmd, input logic signed [31:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.value   <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      deque_apply(cmd, val);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] rand_pop();
      return ($urandom_range(1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
   endfunction

   function automatic logic [2:0] rand_push();
      return ($urandom_range(1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
   endfunction

   // receiver: stall at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: status %0d, element %0d, last %0b",
                   rsp_bus.status, rsp_bus.element, rsp_bus.last);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.element !== want.element) begin
               $error("element mismatch: expected %0d, actual %0d",
                      want.element, rsp_bus.element);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last mismatch: expected %0b, actual %0b", want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog: count cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // empty queue: pops and dump report empty, unused codes give nothing
      send_cmd(CMD_POP_FRONT, $urandom);
      send_cmd(CMD_POP_BACK, $urandom);
      send_cmd(CMD_DUMP, $urandom);
      send_cmd(3'd5, $urandom);
      send_cmd(3'd6, $urandom);
      send_cmd(3'd7, $urandom);
      send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff);
      send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
      send_cmd(CMD_PUSH_BACK, 32'h0000_0000);
      send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
      send_cmd(CMD_PUSH_BACK, 32'h5555_5555);
      send_cmd(CMD_PUSH_FRONT, 32'haaaa_aaaa);
      send_cmd(CMD_DUMP, '0);
      send_cmd(CMD_POP_FRONT, '0);
      send_cmd(CMD_POP_BACK, '0);
      send_cmd(CMD_DUMP, '0);
      send_cmd(CMD_POP_FRONT, '0);
      send_cmd(CMD_POP_BACK, '0);
      send_cmd(CMD_POP_FRONT, '0);
      send_cmd(CMD_POP_BACK, '0);
      send_cmd(CMD_DUMP, '0);
   endtask

   // fill from both ends until full, then try to push past the bound
   task automatic test_fill_to_full();
      idle_pct  = 45;
      stall_pct = 0;
      while (ring_count < DEPTH) send_cmd(rand_push(), rand_word());
      send_cmd(CMD_PUSH_FRONT, rand_word());
      send_cmd(CMD_PUSH_BACK, rand_word());
      send_cmd(CMD_DUMP, $urandom);
   endtask

   // drain under back-pressure with dumps of shrinking length
   task automatic test_drain_with_dumps();
      idle_pct  = 0;
      stall_pct = 45;
      send_cmd(CMD_DUMP, $urandom);
      while (ring_count > 0) begin
         if ($urandom_range(7) == 0) send_cmd(CMD_DUMP, $urandom);
         else send_cmd(rand_pop(), $urandom);
      end
      send_cmd(rand_pop(), $urandom);
      send_cmd(CMD_DUMP, $urandom);
   endtask

   task automatic test_random_mix(input int n_items, input int idle_p, input int stall_p);
      int          i;
      int unsigned pick;
      idle_pct  = idle_p;
      stall_pct = stall_p;
      for (i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 50) send_cmd(rand_push(), rand_word());
         else if (pick < 80) send_cmd(rand_pop(), $urandom);
         else if (pick < 94) send_cmd(CMD_DUMP, $urandom);
         else send_cmd(3'($urandom_range(7, 5)), $urandom);
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = '0;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      fail_count      = 0;
      quiet_cycles    = 0;
      ring_front      = 0;
      ring_count      = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_fill_to_full();
      test_drain_with_dumps();
      test_random_mix(20, 18, 18);

      req_bus.valid <= 1'b0;
      stall_pct = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bdeq_pkg.sv
sv/bdeq_if.sv
sv/bounded_deque_with_dump_core.sv
sv/bdeq_checker.sv
tb/sv/tb.sv
